/* hdl/coverage_grid_stamp_unit_assert.svh */
// assertion macros for the coverage grid stamp unit
// used by the controller and datapath; expects clk and rst_n in scope
`ifndef COVERAGE_GRID_STAMP_UNIT_ASSERT_SVH
`define COVERAGE_GRID_STAMP_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cgs_pkg.sv */
// shared types and constants for the coverage grid stamp unit
// no dependencies
`default_nettype none

package cgs_pkg;

  localparam int GRID_ROWS_DEF = 512;
  localparam int GRID_COLS_DEF = 512;

  localparam int POS_W   = 16;
  localparam int CPM_W   = 8;
  localparam int RAD_W   = 4;
  localparam int IDX_W   = 18;
  localparam int PROD_W  = POS_W + CPM_W + 1;
  localparam int OFS_W   = PROD_W - 8;
  localparam int CNT_W   = RAD_W + 1;
  localparam int CFG_W   = 8;

  localparam logic [CPM_W-1:0] CPM_RESET = 8'd25;
  localparam logic [RAD_W-1:0] RAD_RESET = 4'd5;

  localparam logic [1:0] CELL_UNSEEN  = 2'd0;
  localparam logic [1:0] CELL_NEAR    = 2'd1;
  localparam logic [1:0] CELL_VISITED = 2'd2;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [0:0] {
    CFG_CPM    = 1'b0,
    CFG_RADIUS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_STAMPED = 2'd0,
    ST_VISITED = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    in_load;
    logic    clr_step;
    logic    mul;
    logic    cells;
    logic    rowoff;
    logic    centre;
    logic    rd_centre;
    logic    wr_centre;
    logic    rd_issue;
    logic    nb_start;
    logic    nb_rd;
    logic    nb_wr;
    logic    nb_adv;
    logic    out_load;
    status_t st;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic req_read;
    logic rd_oob;
    logic centre_oob;
    logic centre_visited;
    logic nb_in_range;
    logic nb_unseen;
    logic nb_last;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/cgs_ctrl.sv */
// sequencing state machine for the coverage grid stamp unit
// depends on cgs_pkg and coverage_grid_stamp_unit_assert.svh
`default_nettype none

`include "coverage_grid_stamp_unit_assert.svh"

module cgs_ctrl
  import cgs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    S_CLR    = 14'h0001,
    S_IDLE   = 14'h0002,
    S_MUL    = 14'h0004,
    S_CELLS  = 14'h0008,
    S_ROW    = 14'h0010,
    S_CENTRE = 14'h0020,
    S_CRD    = 14'h0040,
    S_CCHK   = 14'h0080,
    S_NSTART = 14'h0100,
    S_NRD    = 14'h0200,
    S_NCHK   = 14'h0400,
    S_RRD    = 14'h0800,
    S_DONE   = 14'h1000,
    S_SPARE  = 14'h2000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    can_load;

  assign can_load  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (sts.req_read) begin
          if (sts.rd_oob) begin
            st_nxt    = ST_OUTSIDE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RRD;
          end
        end else begin
          state_nxt = S_CELLS;
        end
      end
      S_CELLS: begin
        cmd.cells = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.rowoff = 1'b1;
        state_nxt  = S_CENTRE;
      end
      S_CENTRE: begin
        cmd.centre = 1'b1;
        state_nxt  = S_CRD;
      end
      S_CRD: begin
        if (sts.centre_oob) begin
          st_nxt    = ST_OUTSIDE;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_centre = 1'b1;
          state_nxt     = S_CCHK;
        end
      end
      S_CCHK: begin
        if (sts.centre_visited) begin
          st_nxt    = ST_VISITED;
          state_nxt = S_DONE;
        end else begin
          cmd.wr_centre = 1'b1;
          state_nxt     = S_NSTART;
        end
      end
      S_NSTART: begin
        cmd.nb_start = 1'b1;
        state_nxt    = S_NRD;
      end
      S_NRD: begin
        if (sts.nb_in_range) begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NCHK;
        end else begin
          // cell off the grid, skip the memory
          cmd.nb_adv = 1'b1;
          if (sts.nb_last) begin
            st_nxt    = ST_STAMPED;
            state_nxt = S_DONE;
          end
        end
      end
      S_NCHK: begin
        cmd.nb_wr  = sts.nb_unseen;
        cmd.nb_adv = 1'b1;
        if (sts.nb_last) begin
          st_nxt    = ST_STAMPED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NRD;
        end
      end
      S_RRD: begin
        cmd.rd_issue = 1'b1;
        st_nxt       = ST_READ;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.st = st_r;
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      st_r        <= ST_STAMPED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // one item in flight at a time
  `CGS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item accepted in flight")
  // a finished result waits while the previous output is not yet taken
  `CGS_ASSERT_NEXT(a_done_holds, state_r == S_DONE && out_valid_r && !out_ready,
                   state_r == S_DONE && out_valid_r, "result lost while output stalled")

endmodule

`default_nettype wire

/* hdl/cgs_datapath.sv */
// arithmetic, grid memory, neighbourhood counters and output register
// depends on cgs_pkg and coverage_grid_stamp_unit_assert.svh
`default_nettype none

`include "coverage_grid_stamp_unit_assert.svh"

module cgs_datapath
  import cgs_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_req_type,
  input  logic signed [POS_W-1:0] in_x_pos,
  input  logic signed [POS_W-1:0] in_y_pos,
  input  logic [IDX_W-1:0]        in_read_index,
  output logic [1:0]              out_status,
  output logic [IDX_W-1:0]        out_cell_index,
  output logic [1:0]              out_cell_value,
  input  cmd_t                    cmd,
  output sts_t                    sts
);

  localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
  localparam int AW  = $clog2(CELL_COUNT);
  localparam int CLW = $clog2(GRID_COLS + 1);
  localparam int RW  = OFS_W + CLW + 1;
  localparam int CW  = ((RW > AW + 1) ? RW : AW + 1) + 2;
  localparam int RCW = RAD_W + CLW;

  localparam logic signed [CLW:0]   COLS_S = GRID_COLS[CLW:0];
  localparam logic signed [CW-1:0]  COLS_CW = CW'(GRID_COLS);
  localparam logic signed [CW-1:0]  CELL_S = CW'(CELL_COUNT);
  localparam logic signed [CW-1:0]  HALF_S = CW'(CELL_COUNT / 2);
  localparam logic [AW-1:0]         CLR_END = AW'(CELL_COUNT - 1);

  logic [CPM_W-1:0] cpm_r;
  logic [RAD_W-1:0] rad_r;

  logic                     req_r;
  logic signed [POS_W-1:0]  x_r, y_r;
  logic [IDX_W-1:0]         ri_r;
  logic signed [PROD_W-1:0] px_r, py_r, px_b, py_b;
  logic signed [OFS_W-1:0]  xc_r, yc_r;
  logic signed [RW-1:0]     rowoff_r;
  logic [RCW-1:0]           rcols_r;
  logic signed [CW-1:0]     centre_r, centre_nxt;
  logic signed [CW-1:0]     row_r, s_r;
  logic [CNT_W-1:0]         i_r, j_r, span;
  logic [AW-1:0]            clr_cnt_r;

  logic [1:0]    grid_mem [CELL_COUNT];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [1:0]    mem_wd, rdata_r;

  status_t          out_status_r;
  logic [IDX_W-1:0] out_index_r;
  logic [1:0]       out_value_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpm_r <= CPM_RESET;
      rad_r <= RAD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CPM:    cpm_r <= cfg_wdata;
        CFG_RADIUS: rad_r <= cfg_wdata[RAD_W-1:0];
      endcase
    end
  end

  // round toward zero before the shift
  assign px_b = px_r + (px_r[PROD_W-1] ? PROD_W'(255) : '0);
  assign py_b = py_r + (py_r[PROD_W-1] ? PROD_W'(255) : '0);

  assign centre_nxt = HALF_S - CW'(rowoff_r) + CW'(xc_r);
  assign span       = {rad_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      req_r <= in_req_type;
      x_r   <= in_x_pos;
      y_r   <= in_y_pos;
      ri_r  <= in_read_index;
    end
    if (cmd.mul) begin
      px_r <= x_r * $signed({1'b0, cpm_r});
      py_r <= y_r * $signed({1'b0, cpm_r});
    end
    if (cmd.cells) begin
      xc_r <= px_b[PROD_W-1:8];
      yc_r <= py_b[PROD_W-1:8];
    end
    if (cmd.rowoff) begin
      rowoff_r <= yc_r * COLS_S;
      rcols_r  <= RCW'(rad_r) * RCW'(GRID_COLS[CLW-1:0]);
    end
    if (cmd.centre) begin
      centre_r <= centre_nxt;
    end
    if (cmd.nb_start) begin
      // top-left cell of the square: row -r, column -r
      row_r <= centre_r + CW'(rcols_r) - CW'(rad_r);
      s_r   <= centre_r + CW'(rcols_r) - CW'(rad_r);
      i_r   <= '0;
      j_r   <= '0;
    end else if (cmd.nb_adv) begin
      if (j_r == span) begin
        j_r   <= '0;
        i_r   <= i_r + CNT_W'(1);
        row_r <= row_r - COLS_CW;
        s_r   <= row_r - COLS_CW;
      end else begin
        j_r <= j_r + CNT_W'(1);
        s_r <= s_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step && clr_cnt_r != CLR_END) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // single port access
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wd   = CELL_UNSEEN;
    mem_addr = s_r[AW-1:0];
    priority if (cmd.clr_step) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt_r;
    end else if (cmd.rd_centre) begin
      mem_re   = 1'b1;
      mem_addr = centre_r[AW-1:0];
    end else if (cmd.wr_centre) begin
      mem_we   = 1'b1;
      mem_wd   = CELL_VISITED;
      mem_addr = centre_r[AW-1:0];
    end else if (cmd.rd_issue) begin
      mem_re   = 1'b1;
      mem_addr = AW'(ri_r);
    end else if (cmd.nb_rd) begin
      mem_re = 1'b1;
    end else if (cmd.nb_wr) begin
      mem_we = 1'b1;
      mem_wd = CELL_NEAR;
    end else begin
      mem_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= grid_mem[mem_addr];
    end
  end

  assign sts.clr_last       = (clr_cnt_r == CLR_END);
  assign sts.req_read       = (req_r == REQ_READ);
  assign sts.rd_oob         = (32'(ri_r) >= 32'(CELL_COUNT));
  assign sts.centre_oob     = centre_r[CW-1] || (centre_r >= CELL_S);
  assign sts.centre_visited = (rdata_r == CELL_VISITED);
  assign sts.nb_in_range    = !s_r[CW-1] && (s_r < CELL_S);
  assign sts.nb_unseen      = (rdata_r == CELL_UNSEEN);
  assign sts.nb_last        = (i_r == span) && (j_r == span);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.st;
      unique case (cmd.st)
        ST_READ: begin
          out_index_r <= ri_r;
          out_value_r <= rdata_r;
        end
        ST_OUTSIDE: begin
          out_index_r <= sts.req_read ? ri_r : '0;
          out_value_r <= CELL_UNSEEN;
        end
        ST_STAMPED, ST_VISITED: begin
          out_index_r <= IDX_W'(centre_r[AW-1:0]);
          out_value_r <= CELL_VISITED;
        end
      endcase
    end
  end

  assign out_status     = out_status_r;
  assign out_cell_index = out_index_r;
  assign out_cell_value = out_value_r;

  // a near mark always follows the check read of the same cell
  `CGS_ASSERT_NOW(a_nb_wr_after_rd, cmd.nb_wr, $past(cmd.nb_rd) && rdata_r == CELL_UNSEEN,
                  "near mark without a fresh check read")
  // clearing pass walks the grid one cell a cycle, counted from the edge after reset
  `CGS_ASSERT_NEXT(a_clr_walk, rst_n && cmd.clr_step && clr_cnt_r != CLR_END,
                   clr_cnt_r == $past(clr_cnt_r) + AW'(1), "clearing pass skipped a cell")

endmodule

`default_nettype wire

/* hdl/coverage_grid_stamp_unit.sv */
// top level of the coverage grid stamp unit
// depends on cgs_pkg, cgs_ctrl and cgs_datapath
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   req_type, x_pos, y_pos, read_index
//   out_     output     out_valid / out_ready status, cell_index, cell_value
//   cfg_     input      cfg_wr_en             cfg_index, cfg_wdata
//
// in a position update each neighbour cell in the square that lies on the grid is
// read and, if still unseen, written as near, on the single port of the grid
// memory; cells off the grid skip the memory
// one item is worked on at a time
// after reset a clearing pass over all GRID_ROWS*GRID_COLS cells zeroes the grid,
// in_ready stays low during it; config writes are taken at any time
// a result waiting on out_ready holds the next item back only at its end
`default_nettype none

module coverage_grid_stamp_unit
  import cgs_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_req_type,
  input  logic signed [POS_W-1:0] in_x_pos,
  input  logic signed [POS_W-1:0] in_y_pos,
  input  logic [IDX_W-1:0]        in_read_index,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [IDX_W-1:0]        out_cell_index,
  output logic [1:0]              out_cell_value
);

  cmd_t cmd;
  sts_t sts;

  cgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cgs_datapath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_req_type    (in_req_type),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_read_index  (in_read_index),
    .out_status     (out_status),
    .out_cell_index (out_cell_index),
    .out_cell_value (out_cell_value),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

`default_nettype wire
